// ----- rtl/core/bsl_pkg.sv -----
// ----------------------------------------------------------------------------
// bsl_pkg: shared definitions for the box step limits block
// Number format defaults, bound mode and register codes, step kinds, and the
// command and status groups passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package bsl_pkg;

  // Default number format: signed Q16.16.
  localparam int VALUE_WIDTH_DEF   = 32;
  localparam int FRACTION_BITS_DEF = 16;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_BOUND_MODE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCALAR_LOWER = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCALAR_UPPER = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ORIENTATION  = 2'd3;

  // Bound mode codes; undefined codes behave as no bounds.
  localparam int MODE_W = 4;
  localparam logic [MODE_W-1:0] MODE_NONE         = 4'd0;
  localparam logic [MODE_W-1:0] MODE_SCALAR_LO    = 4'd1;
  localparam logic [MODE_W-1:0] MODE_VECTOR_LO    = 4'd2;
  localparam logic [MODE_W-1:0] MODE_SCALAR_HI    = 4'd3;
  localparam logic [MODE_W-1:0] MODE_SCALAR_BOTH  = 4'd4;
  localparam logic [MODE_W-1:0] MODE_VLO_SHI      = 4'd5;
  localparam logic [MODE_W-1:0] MODE_VECTOR_HI    = 4'd6;
  localparam logic [MODE_W-1:0] MODE_SLO_VHI      = 4'd7;
  localparam logic [MODE_W-1:0] MODE_VECTOR_BOTH  = 4'd8;

  // What one element does to the running limits.
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_INF  = 2'd1,
    KIND_DIV  = 2'd2
  } step_kind_t;

  // Controller to datapath.
  typedef struct packed {
    logic in_ready;
    logic setup;
    logic iterate;
    logic update;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic in_fire;
    logic div_needed;
    logic div_done;
    logic out_blocked;
  } dp_status_t;

endpackage

// ----- rtl/core/bsl_if.sv -----
// ----------------------------------------------------------------------------
// bsl_if: channel interfaces of the box step limits block
// Element input channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface bsl_in_if #(
  parameter int VALUE_WIDTH = bsl_pkg::VALUE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] x_value;
  logic signed [VALUE_WIDTH-1:0] direction_value;
  logic signed [VALUE_WIDTH-1:0] lower_value;
  logic signed [VALUE_WIDTH-1:0] upper_value;
  logic                          last_element;

  modport source (
    output valid, x_value, direction_value, lower_value, upper_value, last_element,
    input  ready
  );
  modport sink (
    input  valid, x_value, direction_value, lower_value, upper_value, last_element,
    output ready
  );
endinterface

interface bsl_out_if #(
  parameter int VALUE_WIDTH = bsl_pkg::VALUE_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] min_step;
  logic signed [VALUE_WIDTH-1:0] min_positive_step;
  logic signed [VALUE_WIDTH-1:0] max_step;

  modport source (
    output valid, min_step, min_positive_step, max_step,
    input  ready
  );
  modport sink (
    input  valid, min_step, min_positive_step, max_step,
    output ready
  );
endinterface

interface bsl_cfg_if #(
  parameter int VALUE_WIDTH = bsl_pkg::VALUE_WIDTH_DEF
);
  logic                               valid;
  logic                               ready;
  logic [bsl_pkg::CFG_INDEX_W-1:0]    index;
  logic [VALUE_WIDTH-1:0]             data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// ----- rtl/core/box_step_limits.sv -----
// ----------------------------------------------------------------------------
// box_step_limits: step limits for a line search inside a box
// Takes one vector element per beat and returns the least step, the least
// positive step and the greatest step on the vector's last element.
//
//   Channel  Dir   Beat contents
//   in_bus   in    x_value, direction_value, lower_value, upper_value,
//                  last_element
//   out_bus  out   min_step, min_positive_step, max_step
//   cfg_bus  in    index (bound_mode, scalar_lower, scalar_upper,
//                  orientation), data
//
// An element that needs a division passes through the accept, set-up, divide
// and update states, the divide state running VALUE_WIDTH - 1 iterations of
// the radix-2 restoring divider. An element that needs no division or whose
// quotient saturates goes from set-up straight to update.
// Reset clears the configuration registers and the running limits.
// A result waiting in the output register does not stop new elements; only
// the update of a last element waits until that register is free.
// ----------------------------------------------------------------------------
module box_step_limits #(
  parameter int VALUE_WIDTH   = bsl_pkg::VALUE_WIDTH_DEF,
  parameter int FRACTION_BITS = bsl_pkg::FRACTION_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bsl_in_if.sink    in_bus,
  bsl_out_if.source out_bus,
  bsl_cfg_if.sink   cfg_bus
);

  bsl_pkg::dp_cmd_t    cmd;
  bsl_pkg::dp_status_t status;

  // Sequencing.
  bsl_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .cmd    (cmd)
  );

  // Arithmetic and storage.
  bsl_datapath #(
    .VALUE_WIDTH   (VALUE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus),
    .cmd     (cmd),
    .status  (status)
  );

endmodule

// ----- rtl/core/bsl_ctrl.sv -----
// ----------------------------------------------------------------------------
// bsl_ctrl: sequencing controller of the box step limits block
// Steps each element through accept, divider set-up, division when needed, and update.
// ----------------------------------------------------------------------------
module bsl_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  bsl_pkg::dp_status_t status,
  output bsl_pkg::dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SETUP  = 4'b0010,
    ST_DIV    = 4'b0100,
    ST_UPDATE = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (status.in_fire) state_nxt = ST_SETUP;
      end
      ST_SETUP: begin
        state_nxt = status.div_needed ? ST_DIV : ST_UPDATE;
      end
      ST_DIV: begin
        if (status.div_done) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (!status.out_blocked) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Commands to the datapath.
  always_comb begin
    cmd.in_ready = (state_r == ST_IDLE);
    cmd.setup    = (state_r == ST_SETUP);
    cmd.iterate  = (state_r == ST_DIV);
    cmd.update   = (state_r == ST_UPDATE) && !status.out_blocked;
  end

endmodule

// ----- rtl/core/bsl_datapath.sv -----
// ----------------------------------------------------------------------------
// bsl_datapath: arithmetic and storage of the box step limits block
// Configuration registers, bound selection, radix-2 restoring divider,
// running limits and the result register.
// ----------------------------------------------------------------------------
module bsl_datapath #(
  parameter int VALUE_WIDTH   = bsl_pkg::VALUE_WIDTH_DEF,
  parameter int FRACTION_BITS = bsl_pkg::FRACTION_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  bsl_in_if.sink              in_bus,
  bsl_out_if.source           out_bus,
  bsl_cfg_if.sink             cfg_bus,
  input  bsl_pkg::dp_cmd_t    cmd,
  output bsl_pkg::dp_status_t status
);

  localparam int VW    = VALUE_WIDTH;
  localparam int FB    = FRACTION_BITS;
  localparam int ZW    = VW + FB;
  localparam int CNT_W = $clog2(VW - 1);
  localparam logic [CNT_W-1:0]    DIV_LAST_CNT = CNT_W'(VW - 2);
  localparam logic signed [VW-1:0] INF_CODE    = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] MIN_CODE    = {1'b1, {(VW-1){1'b0}}};

  // Configuration registers.
  logic [bsl_pkg::MODE_W-1:0] mode_r;
  logic signed [VW-1:0]       slo_r;
  logic signed [VW-1:0]       shi_r;
  logic                       orient_r;

  // Element registers.
  logic [VW-1:0]       nmag_r;
  logic                nneg_r;
  logic [VW-1:0]       pmag_r;
  logic                pneg_r;
  bsl_pkg::step_kind_t kind_r;
  logic                last_r;

  // Divider registers.
  logic [VW-1:0]    rem_r;
  logic [VW-2:0]    zlo_r;
  logic [VW-2:0]    quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             sat_r;

  // Running limits and result register.
  logic signed [VW-1:0] run_min_r, run_min_nxt;
  logic signed [VW-1:0] run_minpos_r, run_minpos_nxt;
  logic signed [VW-1:0] run_max_r, run_max_nxt;
  logic signed [VW-1:0] out_min_r, out_minpos_r, out_max_r;
  logic                 out_valid_r, out_valid_nxt;

  logic in_fire;
  logic out_load;

  assign cfg_bus.ready = 1'b1;
  assign in_bus.ready  = cmd.in_ready;
  assign in_fire       = in_bus.valid && cmd.in_ready;
  assign out_load      = cmd.update && last_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= bsl_pkg::MODE_NONE;
      slo_r    <= '0;
      shi_r    <= '0;
      orient_r <= 1'b0;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.index)
        bsl_pkg::CFG_BOUND_MODE:   mode_r   <= cfg_bus.data[bsl_pkg::MODE_W-1:0];
        bsl_pkg::CFG_SCALAR_LOWER: slo_r    <= cfg_bus.data;
        bsl_pkg::CFG_SCALAR_UPPER: shi_r    <= cfg_bus.data;
        bsl_pkg::CFG_ORIENTATION:  orient_r <= cfg_bus.data[0];
        default: begin
        end
      endcase
    end
  end

  // Bound selection and classification of the incoming element.
  logic                 has_lo, has_hi;
  logic signed [VW-1:0] lo_sel, hi_sel, bnd;
  logic                 p_neg, p_zero, toward_hi;
  logic [VW:0]          diff, diff_abs;
  logic [VW-1:0]        p_abs;
  bsl_pkg::step_kind_t  kind_nxt;

  always_comb begin
    has_lo = 1'b0;
    has_hi = 1'b0;
    lo_sel = slo_r;
    hi_sel = shi_r;
    case (mode_r)
      bsl_pkg::MODE_SCALAR_LO: begin
        has_lo = 1'b1;
      end
      bsl_pkg::MODE_VECTOR_LO: begin
        has_lo = 1'b1;
        lo_sel = in_bus.lower_value;
      end
      bsl_pkg::MODE_SCALAR_HI: begin
        has_hi = 1'b1;
      end
      bsl_pkg::MODE_SCALAR_BOTH: begin
        has_lo = 1'b1;
        has_hi = 1'b1;
      end
      bsl_pkg::MODE_VLO_SHI: begin
        has_lo = 1'b1;
        has_hi = 1'b1;
        lo_sel = in_bus.lower_value;
      end
      bsl_pkg::MODE_VECTOR_HI: begin
        has_hi = 1'b1;
        hi_sel = in_bus.upper_value;
      end
      bsl_pkg::MODE_SLO_VHI: begin
        has_lo = 1'b1;
        has_hi = 1'b1;
        hi_sel = in_bus.upper_value;
      end
      bsl_pkg::MODE_VECTOR_BOTH: begin
        has_lo = 1'b1;
        has_hi = 1'b1;
        lo_sel = in_bus.lower_value;
        hi_sel = in_bus.upper_value;
      end
      default: begin
      end
    endcase

    p_neg     = in_bus.direction_value[VW-1];
    p_zero    = (in_bus.direction_value == '0);
    toward_hi = orient_r ? p_neg : !p_neg;
    bnd       = toward_hi ? hi_sel : lo_sel;

    // Exact distance to the bound, one bit wider than the operands.
    if (orient_r) begin
      diff = {in_bus.x_value[VW-1], in_bus.x_value} - {bnd[VW-1], bnd};
    end else begin
      diff = {bnd[VW-1], bnd} - {in_bus.x_value[VW-1], in_bus.x_value};
    end
    diff_abs = diff[VW] ? (~diff + 1'b1) : diff;
    p_abs    = p_neg ? (~in_bus.direction_value + 1'b1) : in_bus.direction_value;

    if (!has_lo && !has_hi) begin
      kind_nxt = bsl_pkg::KIND_INF;
    end else if (p_zero) begin
      kind_nxt = bsl_pkg::KIND_NONE;
    end else if ((toward_hi && has_hi) || (!toward_hi && has_lo)) begin
      kind_nxt = bsl_pkg::KIND_DIV;
    end else begin
      kind_nxt = bsl_pkg::KIND_INF;
    end
  end

  // Capture the element on its accepted beat.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      nmag_r <= diff_abs[VW-1:0];
      nneg_r <= diff[VW];
      pmag_r <= p_abs;
      pneg_r <= p_neg;
      kind_r <= kind_nxt;
      last_r <= in_bus.last_element;
    end
  end

  // Divider set-up: the scaled dividend's upper part decides saturation.
  logic [ZW-1:0] z_full, z_hi;
  logic          sat;
  assign z_full = {nmag_r, {FB{1'b0}}};
  assign z_hi   = z_full >> (VW - 1);
  assign sat    = (z_hi >= {{FB{1'b0}}, pmag_r});

  // One restoring division step.
  logic [VW:0] trial, trial_sub;
  logic        trial_ge;
  assign trial     = {rem_r, zlo_r[VW-2]};
  assign trial_sub = trial - {1'b0, pmag_r};
  assign trial_ge  = (trial >= {1'b0, pmag_r});

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      rem_r <= z_hi[VW-1:0];
      zlo_r <= z_full[VW-2:0];
      quo_r <= '0;
      cnt_r <= DIV_LAST_CNT;
      sat_r <= sat;
    end else if (cmd.iterate) begin
      rem_r <= trial_ge ? trial_sub[VW-1:0] : trial[VW-1:0];
      zlo_r <= zlo_r << 1;
      quo_r <= {quo_r[VW-3:0], trial_ge};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // Signed, saturated step from the quotient.
  logic                 step_neg;
  logic signed [VW-1:0] quo_ext, step;
  assign step_neg = nneg_r ^ pneg_r;
  assign quo_ext  = {1'b0, quo_r};
  assign step     = sat_r ? (step_neg ? MIN_CODE : INF_CODE)
                          : (step_neg ? -quo_ext : quo_ext);

  // Running limits and the result register.
  always_comb begin
    run_min_nxt    = run_min_r;
    run_minpos_nxt = run_minpos_r;
    run_max_nxt    = run_max_r;
    out_valid_nxt  = out_valid_r && !out_bus.ready;
    if (cmd.update) begin
      if (kind_r == bsl_pkg::KIND_DIV) begin
        if (step < run_min_r) run_min_nxt = step;
        if ((step > 0) && (step < run_minpos_r)) run_minpos_nxt = step;
        if (step > run_max_r) run_max_nxt = step;
      end else if (kind_r == bsl_pkg::KIND_INF) begin
        run_max_nxt = INF_CODE;
      end
    end
    if (out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_min_r    <= INF_CODE;
      run_minpos_r <= INF_CODE;
      run_max_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (out_load) begin
        run_min_r    <= INF_CODE;
        run_minpos_r <= INF_CODE;
        run_max_r    <= '0;
      end else begin
        run_min_r    <= run_min_nxt;
        run_minpos_r <= run_minpos_nxt;
        run_max_r    <= run_max_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_min_r    <= run_min_nxt;
      out_minpos_r <= run_minpos_nxt;
      out_max_r    <= run_max_nxt;
    end
  end

  assign out_bus.valid             = out_valid_r;
  assign out_bus.min_step          = out_min_r;
  assign out_bus.min_positive_step = out_minpos_r;
  assign out_bus.max_step          = out_max_r;

  // Status to the controller.
  always_comb begin
    status.in_fire     = in_fire;
    status.div_needed  = (kind_r == bsl_pkg::KIND_DIV) && !sat;
    status.div_done    = (cnt_r == '0);
    status.out_blocked = last_r && out_valid_r && !out_bus.ready;
  end

  // The partial remainder stays below the divisor throughout the division.
  a_rem_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.iterate |-> (rem_r < pmag_r))
    else $error("partial remainder reached the divisor");

  // The least positive step is always strictly positive.
  a_minpos_positive: assert property (@(posedge clk) disable iff (!rst_n)
    run_minpos_r > 0)
    else $error("least positive step is not positive");

  // A step that lowers the least positive step also bounds the least step, so the two stay ordered.
  a_min_order: assert property (@(posedge clk) disable iff (!rst_n)
    run_min_r <= run_minpos_r)
    else $error("least step exceeds least positive step");

  // Emitting a result presents it and returns the running state to reset.
  a_result_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && (run_min_r == INF_CODE) && (run_max_r == '0)))
    else $error("running limits not cleared after a result");

endmodule
